// ===== rtl/fas_pkg.sv =====
// ----------------------------------------------------------------------------
// fas_pkg
// Types and constants shared by the single-precision adder pipeline.
// ----------------------------------------------------------------------------
package fas_pkg;

	localparam int unsigned EXP_W  = 8;
	localparam int unsigned FRAC_W = 23;
	localparam int unsigned MANT_W = 24;
	localparam logic [EXP_W-1:0] EXP_MAX  = 8'hFF;
	localparam logic [EXP_W-1:0] EXP_TOP  = 8'hFE;

	typedef struct packed {
		logic [31:0] a_bits;
		logic [31:0] b_bits;
		logic        operation;
	} in_t;

	typedef struct packed {
		logic [31:0] result_bits;
		logic        overflow;
		logic        underflow;
	} out_t;

	// Stage 1 to stage 2: operands ordered, smaller one aligned.
	typedef struct packed {
		logic              done;
		logic [31:0]       res;
		logic              bs;
		logic              ss;
		logic [EXP_W-1:0]  be;
		logic [MANT_W-1:0] bm;
		logic [MANT_W-1:0] sm;
	} align_t;

	// Stage 2 to stage 3: sum or difference ready for normalization.
	typedef struct packed {
		logic              done;
		logic [31:0]       res;
		logic              eff_add;
		logic              rs;
		logic [EXP_W-1:0]  be;
		logic [MANT_W:0]   mag;
	} sum_t;

	function automatic logic [31:0] pack_bits(input logic s, input logic [EXP_W-1:0] e,
		input logic [FRAC_W-1:0] m);
		pack_bits = {s, e, m};
	endfunction

endpackage

// ===== rtl/fas_stream_if.sv =====
// ----------------------------------------------------------------------------
// fas_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface fas_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fas_align.sv =====
// ----------------------------------------------------------------------------
// fas_align
// Stage 1 logic: special cases, operand ordering and alignment shift.
// ----------------------------------------------------------------------------
module fas_align (
	input  fas_pkg::in_t    din,
	output fas_pkg::align_t dout
);
	logic                      sa, sb;
	logic [fas_pkg::EXP_W-1:0] ea, eb, diff;
	logic [fas_pkg::FRAC_W-1:0] ma, mb;
	logic [fas_pkg::MANT_W-1:0] sm_full, sm_sh;
	logic                      top, swap;

	always_comb begin
		sa = din.a_bits[31];
		sb = din.b_bits[31] ^ din.operation;
		ea = din.a_bits[30:23];
		eb = din.b_bits[30:23];
		ma = din.a_bits[22:0];
		mb = din.b_bits[22:0];
		swap = ea < eb;
		diff = swap ? (eb - ea) : (ea - eb);
		sm_full = swap ? {1'b1, ma} : {1'b1, mb};
		top = 1'b0;
		sm_sh = sm_full;
		if (diff != '0) begin
			top = (diff <= 8'd24) ? sm_full[5'(diff - 8'd1)] : 1'b0;
			sm_sh = (diff < 8'd24) ? (sm_full >> diff[4:0]) : '0;
		end
		dout.bs = swap ? sb : sa;
		dout.ss = swap ? sa : sb;
		dout.be = swap ? eb : ea;
		dout.bm = swap ? {1'b1, mb} : {1'b1, ma};
		dout.sm = sm_sh + fas_pkg::MANT_W'(top && (sa != sb));
		dout.done = 1'b1;
		dout.res  = '0;
		if (ea == '0)
			dout.res = fas_pkg::pack_bits(sb, eb, mb);
		else if (eb == '0)
			dout.res = din.a_bits;
		else if (sa != sb && ma == mb && ea == eb)
			dout.res = '0;
		else
			dout.done = 1'b0;
	end
endmodule

// ===== rtl/fas_addsub.sv =====
// ----------------------------------------------------------------------------
// fas_addsub
// Stage 2 logic: magnitude add or subtract and result sign.
// ----------------------------------------------------------------------------
module fas_addsub (
	input  fas_pkg::align_t din,
	output fas_pkg::sum_t   dout
);
	always_comb begin
		dout.done    = din.done;
		dout.res     = din.res;
		dout.be      = din.be;
		dout.eff_add = din.bs == din.ss;
		dout.rs      = din.bs;
		if (din.bs == din.ss)
			dout.mag = {1'b0, din.bm} + {1'b0, din.sm};
		else if (din.bm < din.sm) begin
			dout.mag = {1'b0, din.sm - din.bm};
			dout.rs  = din.ss;
		end else
			dout.mag = {1'b0, din.bm - din.sm};
	end
endmodule

// ===== rtl/fas_norm.sv =====
// ----------------------------------------------------------------------------
// fas_norm
// Stage 3 logic: carry shift or leading-zero normalization and packing.
// ----------------------------------------------------------------------------
module fas_norm (
	input  fas_pkg::sum_t din,
	output fas_pkg::out_t dout
);
	logic [4:0]                 cnt;
	logic [fas_pkg::MANT_W-1:0] d, dn;
	logic [fas_pkg::EXP_W:0]    be1;

	always_comb begin
		d   = din.mag[fas_pkg::MANT_W-1:0];
		cnt = 5'd0;
		for (int i = 0; i < fas_pkg::MANT_W; i++) begin
			if (d[i])
				cnt = 5'(fas_pkg::MANT_W - 1 - i);
		end
		dn  = d << cnt;
		be1 = {1'b0, din.be} + 9'd1;
		dout.overflow  = 1'b0;
		dout.underflow = 1'b0;
		if (din.done)
			dout.result_bits = din.res;
		else if (din.eff_add) begin
			if (din.mag[fas_pkg::MANT_W]) begin
				if (be1 > {1'b0, fas_pkg::EXP_TOP}) begin
					dout.overflow    = 1'b1;
					dout.result_bits = fas_pkg::pack_bits(din.rs, fas_pkg::EXP_MAX, '0);
				end else
					dout.result_bits = fas_pkg::pack_bits(din.rs, be1[7:0], din.mag[23:1]);
			end else
				dout.result_bits = fas_pkg::pack_bits(din.rs, din.be, din.mag[22:0]);
		end else if (d == '0)
			dout.result_bits = '0;
		else if (din.be <= {3'b0, cnt}) begin
			dout.underflow   = 1'b1;
			dout.result_bits = fas_pkg::pack_bits(din.rs, '0, '0);
		end else
			dout.result_bits = fas_pkg::pack_bits(din.rs, din.be - {3'b0, cnt}, dn[22:0]);
	end
endmodule

// ===== rtl/float32_add_sub.sv =====
// ----------------------------------------------------------------------------
// float32_add_sub
// Simplified single-precision adder/subtractor, three register stages.
// ----------------------------------------------------------------------------
// Channel  Role   Payload
// in_ch    sink   a_bits, b_bits, operation
// out_ch   source result_bits, overflow, underflow
//
// One transaction enters per cycle while the output is not stalled; each result
// passes through the three stages in order: align, add/subtract, normalize.
// Reset clears the stage valid bits only.
// A stalled output holds every stage that is full; bubbles are filled.
module float32_add_sub (
	input logic clk,
	input logic arst_n,
	fas_stream_if.sink   in_ch,
	fas_stream_if.source out_ch
);
	fas_pkg::align_t a_c, d_s1;
	fas_pkg::sum_t   s_c, d_s2;
	fas_pkg::out_t   o_c, d_s3;
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	fas_align  u_align (.din(in_ch.data), .dout(a_c));
	fas_addsub u_addsub (.din(d_s1), .dout(s_c));
	fas_norm   u_norm (.din(d_s2), .dout(o_c));

	assign en3 = !v_s3 || out_ch.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready  = en1;
	assign out_ch.valid = v_s3;
	assign out_ch.data  = d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) d_s1 <= a_c;
		if (en2) d_s2 <= s_c;
		if (en3) d_s3 <= o_c;
	end
endmodule

// ===== rtl/fas_checker.sv =====
// ----------------------------------------------------------------------------
// fas_checker
// Port-level checks for the adder pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module fas_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_result,
	input logic out_ovf,
	input logic out_unf
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_result))
		else $error("Output transaction changed while stalled.");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_ovf && out_unf))
		else $error("Overflow and underflow raised together.");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ovf |-> out_result[30:0] == 31'h7F800000)
		else $error("Overflow result is not infinity.");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("Input stalled while output drains.");
endmodule

bind float32_add_sub fas_checker u_fas_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_result(out_ch.data.result_bits),
	.out_ovf(out_ch.data.overflow), .out_unf(out_ch.data.underflow)
);
